[src/cdconv_pkg.sv]
// Shared types, constants, a conversion helper and a leading-zero count for the depthwise convolution block.
package cdconv_pkg;

   localparam int MAX_CHANNELS = 256;
   localparam int MAX_TAPS     = 8;
   localparam int HIST_ROWS    = MAX_TAPS - 1;
   localparam int HIST_DEPTH   = MAX_CHANNELS * HIST_ROWS;
   localparam int HIST_AW      = $clog2(HIST_DEPTH);
   localparam int WGT_DEPTH    = MAX_CHANNELS * MAX_TAPS;
   localparam int WGT_AW       = $clog2(WGT_DEPTH);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_WEIGHT = 1'b1;

   localparam logic [3:0] CSR_CHANNELS = 4'd0;
   localparam logic [3:0] CSR_TAPS     = 4'd1;

   localparam logic FOP_MUL = 1'b0;
   localparam logic FOP_ADD = 1'b1;

   localparam logic [31:0] DEFAULT_NAN = 32'hffc0_0000;
   localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
   localparam logic [31:0] EXP_MASK    = 32'h7f80_0000;

   typedef struct packed {
      logic        kind;
      logic [31:0] sample_bits;
      logic        sequence_start;
      logic [7:0]  wgt_chan;
      logic [2:0]  weight_tap;
      logic [15:0] weight_half;
   } req_type;

   typedef struct packed {
      logic [31:0] result_bits;
      logic [7:0]  result_channel;
      logic        row_end;
   } rsp_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] data;
      logic [7:0]  channel;
      logic [2:0]  tap;
      logic [2:0]  rows;
      logic [3:0]  taps;
      logic        row_end;
   } item_type;

   typedef struct packed {
      logic        start;
      logic        op;
      logic [31:0] a;
      logic [31:0] b;
   } fpu_req_type;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [31:0] r;
      logic [4:0]  e;
      logic [9:0]  m;
      logic [3:0]  n;
      logic [10:0] mm;
      e = h[14:10];
      m = h[9:0];
      n = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (m[i]) begin
            n = 4'(10 - i);
         end
      end
      mm = {1'b0, m} << n;
      if (e == 5'd0) begin
         if (m == 10'd0) begin
            r = {h[15], 31'd0};
         end else begin
            r = {h[15], 8'(8'd113 - {4'd0, n}), mm[9:0], 13'd0};
         end
      end else if (e == 5'd31) begin
         r = {h[15], 8'hff, m, 13'd0};
      end else begin
         r = {h[15], 8'({3'd0, e} + 8'd112), m, 13'd0};
      end
      return r;
   endfunction

   function automatic logic [5:0] lzc50(input logic [49:0] m);
      logic [5:0] n;
      n = 6'd50;
      for (int i = 0; i < 50; i++) begin
         if (m[i]) begin
            n = 6'(49 - i);
         end
      end
      return n;
   endfunction

endpackage

[src/causal_depthwise_conv1d_top.sv]
// Top level of the causal depthwise 1-D convolution block.
//
//   Port group  Direction  Beat contents
//   req_        in         one sample or one weight write (req_type)
//   rsp_        out        one filter result per sample (rsp_type)
//   csr_        in         register index and write data
//
// In the back end a sample runs through eight history steps, and each tap that contributes
// uses the shared four-stage arithmetic unit for one multiply then one add.
// A weight write goes to the weight memory when it leaves the queue.
// The queue holds four beats, so the input keeps accepting while the back end works, until the queue is full.
// Reset is synchronous; the weight and history memories are not cleared.
// The result register holds a finished beat while the next sample is computed.
module causal_depthwise_conv1d_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cdconv_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cdconv_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [8:0]          csr_data
);
   import cdconv_pkg::*;

   logic        q_push, q_full, q_pop, q_valid;
   item_type    q_item, q_head;
   fpu_req_type fpu_req;
   logic        fpu_done;
   logic [31:0] fpu_result;

   cdconv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_push      (q_push),
      .q_item      (q_item),
      .q_full      (q_full)
   );

   cdconv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_item  (q_item),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_valid (q_valid),
      .q_head  (q_head)
   );

   cdconv_fpu u_fpu (
      .clock      (clock),
      .reset      (reset),
      .fpu_req    (fpu_req),
      .fpu_done   (fpu_done),
      .fpu_result (fpu_result)
   );

   cdconv_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .fpu_req     (fpu_req),
      .fpu_done    (fpu_done),
      .fpu_result  (fpu_result),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

[src/cdconv_front.sv]
// Front end: configuration registers, row and channel tracking, item classification.
module cdconv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cdconv_pkg::req_type req_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [8:0]          csr_data,
   output logic                q_push,
   output cdconv_pkg::item_type q_item,
   input  logic                q_full
);
   import cdconv_pkg::*;

   logic [8:0] channels_ff, channels_in;
   logic [3:0] taps_ff, taps_in;
   logic [7:0] pos_ff, pos_in;
   logic [2:0] rows_ff, rows_in;
   logic [8:0] nch;
   logic [3:0] ktaps;
   logic [7:0] pos_cur;
   logic [2:0] rows_cur;
   logic       row_end;
   logic       accept;

   assign req_ready = !q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept;

   always_comb begin
      if (channels_ff == 9'd0) begin
         nch = 9'd1;
      end else if (channels_ff > 9'(MAX_CHANNELS)) begin
         nch = 9'(MAX_CHANNELS);
      end else begin
         nch = channels_ff;
      end
      ktaps    = (taps_ff > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : taps_ff;
      pos_cur  = req_payload.sequence_start ? 8'd0 : pos_ff;
      rows_cur = req_payload.sequence_start ? 3'd0 : rows_ff;
      row_end  = ({1'b0, pos_cur} + 9'd1) >= nch;

      q_item.kind    = req_payload.kind;
      q_item.data    = (req_payload.kind == KIND_WEIGHT) ?
                       {16'd0, req_payload.weight_half} : req_payload.sample_bits;
      q_item.channel = (req_payload.kind == KIND_WEIGHT) ?
                       req_payload.wgt_chan : pos_cur;
      q_item.tap     = req_payload.weight_tap;
      q_item.rows    = rows_cur;
      q_item.taps    = ktaps;
      q_item.row_end = row_end;

      pos_in  = pos_ff;
      rows_in = rows_ff;
      if (accept && req_payload.kind == KIND_SAMPLE) begin
         if (row_end) begin
            pos_in  = 8'd0;
            rows_in = (rows_cur != 3'(MAX_TAPS - 1)) ? rows_cur + 3'd1 : rows_cur;
         end else begin
            pos_in  = pos_cur + 8'd1;
            rows_in = rows_cur;
         end
      end

      channels_in = channels_ff;
      taps_in     = taps_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHANNELS: channels_in = csr_data;
            CSR_TAPS:     taps_in     = csr_data[3:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channels_ff <= 9'd1;
         taps_ff     <= 4'd4;
         pos_ff      <= 8'd0;
         rows_ff     <= 3'd0;
      end else begin
         channels_ff <= channels_in;
         taps_ff     <= taps_in;
         pos_ff      <= pos_in;
         rows_ff     <= rows_in;
      end
   end

endmodule

[src/cdconv_queue.sv]
// Short item queue between the front end and the back end.
module cdconv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_push,
   input  cdconv_pkg::item_type q_item,
   output logic                 q_full,
   input  logic                 q_pop,
   output logic                 q_valid,
   output cdconv_pkg::item_type q_head
);
   import cdconv_pkg::*;

   item_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]       count_ff, count_in;

   assign q_full  = count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (q_push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!q_push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entry_ff[wr_ptr_ff] <= q_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[src/cdconv_fpu.sv]
// Four-stage binary32 multiply and add unit with round to nearest even.
module cdconv_fpu (
   input  logic                    clock,
   input  logic                    reset,
   input  cdconv_pkg::fpu_req_type fpu_req,
   output logic                    fpu_done,
   output logic [31:0]             fpu_result
);
   import cdconv_pkg::*;

   logic        sa, sb;
   logic [7:0]  ea, eb, eau, ebu;
   logic [22:0] fa, fb;
   logic [23:0] ma, mb;
   logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
   logic        spec;
   logic [31:0] spec_bits;
   logic        a_big;
   logic [23:0] big_m, small_m;
   logic [7:0]  big_e, small_e, exp_gap;
   logic [26:0] small_ext, aligned_raw, aligned;
   logic        align_lost;

   logic               s1_valid_ff, s1_op_ff, s1_spec_ff, s1_sign_ff, s1_sub_ff, s1_zsign_ff;
   logic [31:0]        s1_spec_bits_ff;
   logic signed [10:0] s1_exp_ff, s1_exp_in;
   logic [47:0]        s1_prod_ff;
   logic [26:0]        s1_big_ff, s1_small_ff;

   logic [27:0]        sum28;
   logic [49:0]        s2_mant_in;
   logic signed [10:0] s2_exp_in;
   logic               s2_sign_in;
   logic               s2_valid_ff, s2_spec_ff, s2_sign_ff;
   logic [31:0]        s2_spec_bits_ff;
   logic signed [10:0] s2_exp_ff;
   logic [49:0]        s2_mant_ff;

   logic [5:0]         lz;
   logic [49:0]        mant_norm, mant_rnd;
   logic signed [10:0] exp_norm, shift_amt;
   logic [7:0]         exp_field;
   logic               lost;
   logic               s3_valid_ff, s3_spec_ff, s3_sign_ff, s3_zero_ff, s3_ovf_ff, s3_lost_ff;
   logic [31:0]        s3_spec_bits_ff;
   logic [7:0]         s3_exp_ff;
   logic [49:0]        s3_mant_ff;

   logic               round_up;
   logic [30:0]        packed_bits;
   logic [31:0]        result_in;
   logic               done_ff;
   logic [31:0]        result_ff;

   always_comb begin
      sa = fpu_req.a[31];
      sb = fpu_req.b[31];
      ea = fpu_req.a[30:23];
      eb = fpu_req.b[30:23];
      fa = fpu_req.a[22:0];
      fb = fpu_req.b[22:0];
      nan_a  = (ea == 8'hff) && (fa != 23'd0);
      nan_b  = (eb == 8'hff) && (fb != 23'd0);
      inf_a  = (ea == 8'hff) && (fa == 23'd0);
      inf_b  = (eb == 8'hff) && (fb == 23'd0);
      zero_a = (ea == 8'd0) && (fa == 23'd0);
      zero_b = (eb == 8'd0) && (fb == 23'd0);
      ma  = {ea != 8'd0, fa};
      mb  = {eb != 8'd0, fb};
      eau = (ea == 8'd0) ? 8'd1 : ea;
      ebu = (eb == 8'd0) ? 8'd1 : eb;

      spec      = 1'b0;
      spec_bits = DEFAULT_NAN;
      if (nan_a) begin
         spec      = 1'b1;
         spec_bits = fpu_req.a | QUIET_BIT;
      end else if (nan_b) begin
         spec      = 1'b1;
         spec_bits = fpu_req.b | QUIET_BIT;
      end else if (fpu_req.op == FOP_MUL) begin
         if ((inf_a && zero_b) || (zero_a && inf_b)) begin
            spec      = 1'b1;
            spec_bits = DEFAULT_NAN;
         end else if (inf_a || inf_b) begin
            spec      = 1'b1;
            spec_bits = {sa ^ sb, 31'd0} | EXP_MASK;
         end
      end else begin
         if (inf_a && inf_b && (sa != sb)) begin
            spec      = 1'b1;
            spec_bits = DEFAULT_NAN;
         end else if (inf_a) begin
            spec      = 1'b1;
            spec_bits = fpu_req.a;
         end else if (inf_b) begin
            spec      = 1'b1;
            spec_bits = fpu_req.b;
         end
      end

      a_big   = {eau, ma} >= {ebu, mb};
      big_m   = a_big ? ma : mb;
      small_m = a_big ? mb : ma;
      big_e   = a_big ? eau : ebu;
      small_e = a_big ? ebu : eau;
      exp_gap = big_e - small_e;
      small_ext   = {small_m, 3'd0};
      aligned_raw = small_ext >> exp_gap[4:0];
      align_lost  = (aligned_raw << exp_gap[4:0]) != small_ext;
      if (exp_gap >= 8'd27) begin
         aligned = {26'd0, small_m != 24'd0};
      end else begin
         aligned = {aligned_raw[26:1], aligned_raw[0] | align_lost};
      end

      if (fpu_req.op == FOP_MUL) begin
         s1_exp_in = $signed({3'd0, eau}) + $signed({3'd0, ebu}) - 11'sd126;
      end else begin
         s1_exp_in = $signed({3'd0, big_e});
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff        <= fpu_req.op;
      s1_spec_ff      <= spec;
      s1_spec_bits_ff <= spec_bits;
      s1_sign_ff      <= (fpu_req.op == FOP_MUL) ? (sa ^ sb) : (a_big ? sa : sb);
      s1_sub_ff       <= sa ^ sb;
      s1_zsign_ff     <= sa & sb;
      s1_exp_ff       <= s1_exp_in;
      s1_prod_ff      <= ma * mb;
      s1_big_ff       <= {big_m, 3'd0};
      s1_small_ff     <= aligned;
   end

   always_comb begin
      sum28 = s1_sub_ff ? ({1'b0, s1_big_ff} - {1'b0, s1_small_ff}) :
                          ({1'b0, s1_big_ff} + {1'b0, s1_small_ff});
      if (s1_op_ff == FOP_MUL) begin
         s2_mant_in = {s1_prod_ff, 2'd0};
         s2_exp_in  = s1_exp_ff;
         s2_sign_in = s1_sign_ff;
      end else begin
         s2_mant_in = {sum28, 22'd0};
         s2_exp_in  = s1_exp_ff + 11'sd1;
         s2_sign_in = (sum28 == 28'd0) ? s1_zsign_ff : s1_sign_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_spec_ff      <= s1_spec_ff;
      s2_spec_bits_ff <= s1_spec_bits_ff;
      s2_sign_ff      <= s2_sign_in;
      s2_exp_ff       <= s2_exp_in;
      s2_mant_ff      <= s2_mant_in;
   end

   always_comb begin
      lz        = lzc50(s2_mant_ff);
      mant_norm = s2_mant_ff << lz;
      exp_norm  = s2_exp_ff - $signed({5'd0, lz});
      shift_amt = 11'sd1 - exp_norm;
      mant_rnd  = mant_norm;
      lost      = 1'b0;
      exp_field = exp_norm[7:0];
      if (exp_norm <= 11'sd0) begin
         exp_field = 8'd0;
         if (shift_amt >= 11'sd50) begin
            mant_rnd = 50'd0;
            lost     = mant_norm != 50'd0;
         end else begin
            mant_rnd = mant_norm >> shift_amt[5:0];
            lost     = (mant_rnd << shift_amt[5:0]) != mant_norm;
         end
      end
   end

   always_ff @(posedge clock) begin
      s3_spec_ff      <= s2_spec_ff;
      s3_spec_bits_ff <= s2_spec_bits_ff;
      s3_sign_ff      <= s2_sign_ff;
      s3_zero_ff      <= s2_mant_ff == 50'd0;
      s3_ovf_ff       <= exp_norm >= 11'sd255;
      s3_lost_ff      <= lost;
      s3_exp_ff       <= exp_field;
      s3_mant_ff      <= mant_rnd;
   end

   always_comb begin
      round_up    = s3_mant_ff[25] && ((|s3_mant_ff[24:0]) || s3_lost_ff || s3_mant_ff[26]);
      packed_bits = {s3_exp_ff, s3_mant_ff[48:26]} + 31'(round_up);
      if (s3_spec_ff) begin
         result_in = s3_spec_bits_ff;
      end else if (s3_zero_ff) begin
         result_in = {s3_sign_ff, 31'd0};
      end else if (s3_ovf_ff) begin
         result_in = {s3_sign_ff, 31'd0} | EXP_MASK;
      end else begin
         result_in = {s3_sign_ff, packed_bits};
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= fpu_req.start;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         done_ff     <= s3_valid_ff;
      end
   end

   assign fpu_done   = done_ff;
   assign fpu_result = result_ff;

endmodule

[src/cdconv_back.sv]
// Back end: weight and history memories, tap sequencer and result register.
module cdconv_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  cdconv_pkg::item_type    q_head,
   output logic                    q_pop,
   output cdconv_pkg::fpu_req_type fpu_req,
   input  logic                    fpu_done,
   input  logic [31:0]             fpu_result,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cdconv_pkg::rsp_type     rsp_payload
);
   import cdconv_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_USE  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_ADD  = 3'd4;
   localparam logic [2:0] ST_NEXT = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam logic [2:0] LAST_STEP = 3'(MAX_TAPS - 1);

   logic [15:0] wgt_mem [WGT_DEPTH];
   logic [31:0] hist_mem [HIST_DEPTH];

   logic [2:0]  state_ff, state_in;
   logic [2:0]  step_ff, step_in;
   logic [31:0] sum_ff, sum_in;
   item_type    cur_ff, cur_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [15:0]         wgt_rd_ff;
   logic [31:0]         hist_rd_ff;
   logic [HIST_AW-1:0]  base;
   logic [2:0]          idx;
   logic [3:0]          back;
   logic [3:0]          tap4;
   logic [WGT_AW-1:0]   wgt_ra, wgt_wa;
   logic                wgt_we;
   logic [HIST_AW-1:0]  hist_ra, hist_wa;
   logic                hist_we;
   logic [31:0]         hist_wd;
   logic                tap_used;
   logic [31:0]         sval;

   always_comb begin
      base     = HIST_AW'(cur_ff.channel * HIST_ROWS);
      idx      = 3'(HIST_ROWS - 1) - step_ff;
      back     = 4'(MAX_TAPS - 1) - {1'b0, step_ff};
      tap4     = cur_ff.taps - 4'd1 - back;
      tap_used = (back < cur_ff.taps) && (back <= {1'b0, cur_ff.rows});
      sval     = (step_ff == LAST_STEP) ? cur_ff.data : hist_rd_ff;
      hist_ra  = base + HIST_AW'(idx);
      wgt_ra   = {cur_ff.channel, tap4[2:0]};
      wgt_we   = 1'b0;
      wgt_wa   = {q_head.channel, q_head.tap};

      hist_we = 1'b0;
      hist_wa = base;
      hist_wd = cur_ff.data;
      if (state_ff == ST_USE && step_ff != 3'd0 && step_ff != LAST_STEP) begin
         hist_we = 1'b1;
         hist_wa = base + HIST_AW'(idx) + HIST_AW'(1);
         hist_wd = hist_rd_ff;
      end else if (state_ff == ST_NEXT && step_ff == LAST_STEP) begin
         hist_we = 1'b1;
      end

      fpu_req.start = 1'b0;
      fpu_req.op    = FOP_MUL;
      fpu_req.a     = sval;
      fpu_req.b     = half_to_single(wgt_rd_ff);
      if (state_ff == ST_USE && tap_used) begin
         fpu_req.start = 1'b1;
      end else if (state_ff == ST_MUL && fpu_done) begin
         fpu_req.start = 1'b1;
         fpu_req.op    = FOP_ADD;
         fpu_req.a     = sum_ff;
         fpu_req.b     = fpu_result;
      end

      state_in     = state_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      cur_in       = cur_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_head.kind == KIND_WEIGHT) begin
                  wgt_we = 1'b1;
               end else begin
                  cur_in   = q_head;
                  step_in  = 3'd0;
                  sum_in   = 32'd0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_USE;
         end
         ST_USE: begin
            state_in = tap_used ? ST_MUL : ST_NEXT;
         end
         ST_MUL: begin
            if (fpu_done) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fpu_done) begin
               sum_in   = fpu_result;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in  = step_ff + 3'd1;
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_in.result_bits    = sum_ff;
               rsp_in.result_channel = cur_ff.channel;
               rsp_in.row_end        = cur_ff.row_end;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wgt_we) begin
         wgt_mem[wgt_wa] <= q_head.data[15:0];
      end
      wgt_rd_ff <= wgt_mem[wgt_ra];
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      sum_ff  <= sum_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      fpu_done |-> (state_ff == ST_MUL || state_ff == ST_ADD))
      else $error("arithmetic result arrived outside a wait state");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_read_then_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_USE))
      else $error("memory read not followed by its use");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && state_in == ST_IDLE) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while full");

endmodule

[tb/cdconv_checker.sv]
// Checker that predicts and compares every result beat of the convolution block.
`timescale 1ns / 100ps

module cdconv_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  cdconv_pkg::req_type req_payload,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  cdconv_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [8:0]          csr_data,
   output int                  fail_count,
   output int                  pending
);
   import cdconv_pkg::*;

   localparam logic [31:0] QNAN_DEFAULT = 32'hffc0_0000;
   localparam logic [31:0] QUIET_MASK   = 32'h0040_0000;

   logic [8:0]  chan_reg;
   logic [3:0]  tap_reg;
   logic [15:0] coef [MAX_CHANNELS][MAX_TAPS];
   logic [31:0] past [MAX_CHANNELS][MAX_TAPS];
   int          rows_done;
   int          next_chan;
   rsp_type     result_q [$];

   function automatic bit is_nan(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] != 23'd0;
   endfunction

   function automatic bit is_inf(logic [31:0] a);
      return a[30:23] == 8'hff && a[22:0] == 23'd0;
   endfunction

   function automatic logic [31:0] widen_half(logic [15:0] h);
      logic [9:0] m;
      int         e;
      m = h[9:0];
      if (h[14:10] == 5'd0) begin
         if (m == 10'd0) begin
            return {h[15], 31'd0};
         end
         e = 113;
         while (!m[9]) begin
            m = m << 1;
            e--;
         end
         e--;
         m = m << 1;
         return {h[15], 8'(e), m, 13'd0};
      end else if (h[14:10] == 5'd31) begin
         return {h[15], 8'hff, m, 13'd0};
      end
      return {h[15], 8'(h[14:10] + 112), m, 13'd0};
   endfunction

   function automatic real single_to_real(logic [31:0] a);
      logic [22:0] m;
      int          e;
      m = a[22:0];
      if (a[30:23] == 8'd0) begin
         if (m == 23'd0) begin
            return $bitstoreal({a[31], 63'd0});
         end
         e = 1023 - 126;
         while (!m[22]) begin
            m = m << 1;
            e--;
         end
         m = m << 1;
         e--;
         return $bitstoreal({a[31], 11'(e), m, 29'd0});
      end
      return $bitstoreal({a[31], 11'(int'(a[30:23]) - 127 + 1023), m, 29'd0});
   endfunction

   function automatic logic [31:0] real_to_single(real r);
      logic [63:0] d;
      logic [63:0] m;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] halfway;
      logic [63:0] bits;
      int          es;
      int          sh;
      d = $realtobits(r);
      if (d[62:52] == 11'd0) begin
         return {d[63], 31'd0};
      end
      es = int'(d[62:52]) - 1023 + 127;
      m = {11'd1, d[51:0]};
      sh = (es >= 1) ? 29 : 29 + 1 - es;
      if (sh > 60) begin
         sh = 60;
      end
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 64'd1);
      halfway = 64'd1 << (sh - 1);
      if (rem > halfway || (rem == halfway && q[0])) begin
         q = q + 64'd1;
      end
      bits = (es >= 1) ? ((64'(es - 1) << 23) + q) : q;
      if (bits >= 64'h7f80_0000) begin
         return {d[63], 8'hff, 23'd0};
      end
      return {d[63], bits[30:0]};
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      if (is_nan(a)) return a | QUIET_MASK;
      if (is_nan(b)) return b | QUIET_MASK;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return QNAN_DEFAULT;
         return {a[31] ^ b[31], 8'hff, 23'd0};
      end
      return real_to_single(single_to_real(a) * single_to_real(b));
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      if (is_nan(a)) return a | QUIET_MASK;
      if (is_nan(b)) return b | QUIET_MASK;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return QNAN_DEFAULT;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      return real_to_single(single_to_real(a) + single_to_real(b));
   endfunction

   task automatic filter_sample(req_type p);
      int          nch;
      int          k;
      int          ch;
      int          back;
      logic [31:0] acc;
      logic [31:0] s;
      rsp_type     r;
      nch = (chan_reg == 9'd0) ? 1 : ((chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg);
      k = (tap_reg > MAX_TAPS) ? MAX_TAPS : tap_reg;
      if (p.sequence_start) begin
         rows_done = 0;
         next_chan = 0;
      end
      ch = next_chan;
      acc = 32'd0;
      for (int t = 0; t < k; t++) begin
         back = k - 1 - t;
         if (back <= rows_done) begin
            s = (back == 0) ? p.sample_bits : past[ch][back - 1];
            acc = fp_add(acc, fp_mul(s, widen_half(coef[ch][t])));
         end
      end
      for (int j = MAX_TAPS - 1; j > 0; j--) begin
         past[ch][j] = past[ch][j - 1];
      end
      past[ch][0] = p.sample_bits;
      r.result_bits = acc;
      r.result_channel = 8'(ch);
      r.row_end = (ch + 1 >= nch);
      result_q.push_back(r);
      if (r.row_end) begin
         next_chan = 0;
         if (rows_done < MAX_TAPS - 1) rows_done++;
      end else begin
         next_chan = ch + 1;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      chan_reg = 9'd1;
      tap_reg = 4'd4;
      rows_done = 0;
      next_chan = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         chan_reg = 9'd1;
         tap_reg = 4'd4;
         rows_done = 0;
         next_chan = 0;
         result_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CHANNELS) chan_reg = csr_data;
            else if (csr_index == CSR_TAPS) tap_reg = csr_data[3:0];
         end
         if (req_valid && req_ready) begin
            if (req_payload.kind == KIND_WEIGHT) begin
               coef[req_payload.wgt_chan][req_payload.weight_tap] =
                  req_payload.weight_half;
            end else begin
               filter_sample(req_payload);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("Unexpected result beat: %h", rsp_payload);
               end
            end else begin
               want = result_q.pop_front();
               if (want !== rsp_payload) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("Mismatch: expected bits %h ch %0d end %b, got bits %h ch %0d end %b",
                        want.result_bits, want.result_channel, want.row_end,
                        rsp_payload.result_bits, rsp_payload.result_channel,
                        rsp_payload.row_end);
                  end
               end
            end
         end
      end
      pending = result_q.size();
   end

endmodule

[tb/causal_depthwise_conv1d_top_tb.sv]
// Testbench top: stimulus, flow control and verdict for the convolution block.
`timescale 1ns / 100ps

module causal_depthwise_conv1d_top_tb;
   import cdconv_pkg::*;

   localparam int CYCLE_LIMIT   = 3000000;
   localparam int SETTLE        = 150;
   localparam int NARROW_CH     = 8;
   localparam int SAMPLE_TARGET = 1500;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;
   logic    csr_valid;
   logic    csr_ready;
   logic [3:0] csr_index;
   logic [8:0] csr_data;
   int      fail_count;
   int      pending;

   bit      calm;
   int      samples_sent;
   int      cur_nch;
   int      seq_min_nch;
   bit      need_start;
   int      cycles;
   int      ready_hold;
   bit      ready_level;

   causal_depthwise_conv1d_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   cdconv_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      rsp_ready = 1'b0;
      ready_hold = 0;
      ready_level = 1'b0;
      forever begin
         @(posedge clock);
         if (calm) begin
            ready_level = 1'b1;
            ready_hold = 0;
         end else if (ready_hold == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  ready_level = 1'b1;
                  ready_hold = $urandom_range(1, 20);
               end
               6, 7, 8: begin
                  ready_level = 1'b0;
                  ready_hold = $urandom_range(1, 3);
               end
               default: begin
                  ready_level = 1'b0;
                  ready_hold = $urandom_range(10, 60);
               end
            endcase
         end else begin
            ready_hold--;
         end
         rsp_ready <= ready_level;
      end
   end

   function automatic int eff_channels(int v);
      return (v == 0) ? 1 : ((v > MAX_CHANNELS) ? MAX_CHANNELS : v);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return {1'($urandom), 8'($urandom_range(100, 154)), 23'($urandom)};
      if (r < 85) return $urandom;
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7f80_0000;
         3: return 32'hff80_0000;
         4: return 32'h7fc0_1234;
         5: return 32'h7f80_0001;
         6: return 32'h7f7f_ffff;
         default: return 32'h0000_0001;
      endcase
   endfunction

   function automatic logic [15:0] pick_half();
      if ($urandom_range(0, 3) != 0) begin
         return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
      end
      return 16'($urandom);
   endfunction

   task automatic put_beat(req_type p);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      if (p.kind == KIND_SAMPLE) samples_sent++;
   endtask

   task automatic put_sample(logic [31:0] bits, bit start);
      req_type p;
      p = req_type'(($bits(req_type))'({$urandom, $urandom}));
      p.kind = KIND_SAMPLE;
      p.sample_bits = bits;
      p.sequence_start = start;
      if (start) seq_min_nch = cur_nch;
      put_beat(p);
   endtask

   task automatic put_weight(int ch, int tap, logic [15:0] h);
      req_type p;
      p = req_type'(($bits(req_type))'({$urandom, $urandom}));
      p.kind = KIND_WEIGHT;
      p.wgt_chan = 8'(ch);
      p.weight_tap = 3'(tap);
      p.weight_half = h;
      put_beat(p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [3:0] idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 9'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(int nch, int taps);
      drain();
      csr_write(CSR_CHANNELS, nch);
      csr_write(CSR_TAPS, taps);
      if (cur_nch > NARROW_CH) need_start = 1'b1;
      cur_nch = eff_channels(nch);
      if (cur_nch > seq_min_nch) need_start = 1'b1;
      else seq_min_nch = cur_nch;
   endtask

   task automatic run_stream(int count);
      bit start;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) begin
            put_weight($urandom_range(0, 255), $urandom_range(0, 7), pick_half());
         end
         start = need_start || (i == 0 && $urandom_range(0, 4) != 0) ||
                 $urandom_range(0, 49) == 0;
         need_start = 1'b0;
         put_sample(pick_sample(), start);
      end
   endtask

   initial begin
      int nch;
      int taps;
      int rows;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_index = CSR_CHANNELS;
      csr_data = '0;
      calm = 1'b0;
      samples_sent = 0;
      cur_nch = 1;
      seq_min_nch = 1;
      need_start = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm = 1'b1;
      for (int c = 0; c < MAX_CHANNELS; c++) begin
         for (int t = 0; t < ((c < NARROW_CH) ? MAX_TAPS : 1); t++) begin
            put_weight(c, t, pick_half());
         end
      end
      calm = 1'b0;

      put_sample(32'h3f80_0000, 1'b0);
      put_sample(32'h0000_0000, 1'b0);
      put_sample(32'h8000_0000, 1'b0);
      put_weight(0, 3, 16'h7c00);
      put_sample(32'h7f7f_ffff, 1'b0);
      put_sample(32'h0000_0001, 1'b0);
      put_weight(0, 2, 16'h0001);
      put_weight(0, 3, 16'h8000);
      put_sample(32'h7f80_0000, 1'b1);
      put_sample(32'hff80_0000, 1'b0);
      put_weight(0, 1, 16'h7e01);
      put_sample(32'h7f80_0001, 1'b0);
      put_sample(32'hffff_ffff, 1'b0);
      put_weight(0, 3, 16'h03ff);

      set_config(0, 0);
      run_stream(4);
      set_config(511, 1);
      run_stream(MAX_CHANNELS + 3);
      set_config(8, 5);
      need_start = 1'b1;
      run_stream(13);
      set_config(3, 5);
      run_stream(7);
      set_config(MAX_CHANNELS, 1);
      run_stream(5);
      set_config(1, 8);

      while (samples_sent < SAMPLE_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 19))
               0: nch = 511;
               1: nch = MAX_CHANNELS;
               2: nch = 0;
               default: nch = $urandom_range(1, NARROW_CH);
            endcase
            case ($urandom_range(0, 9))
               0: taps = 0;
               1: taps = $urandom_range(9, 15);
               default: taps = $urandom_range(1, 8);
            endcase
            if (eff_channels(nch) > NARROW_CH) taps = $urandom_range(0, 1);
            set_config(nch, taps);
         end
         rows = (cur_nch > 16) ? $urandom_range(1, 2) : $urandom_range(1, 12);
         run_stream(rows * cur_nch + $urandom_range(0, cur_nch - 1));
      end

      calm = 1'b0;
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
